>>> sv/lkm_pkg.sv
package lkm_pkg;

  localparam int MAX_KEY   = 16;
  localparam int LINE_BITS = 24;
  localparam int KEY_LEN_W = 5;
  localparam int CFG_W     = 64;
  localparam int BYTE_W    = 8;
  localparam int OUT_LINE_W = 24;

  localparam logic [BYTE_W-1:0]    NEWLINE_BYTE = 8'd10;
  localparam logic [LINE_BITS-1:0] LINE_MAX     = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_FIRST   = LINE_BITS'(1);

  typedef enum logic [1:0] {
    REG_KEY_LO  = 2'd0,
    REG_KEY_HI  = 2'd1,
    REG_KEY_LEN = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

>>> sv/lkm_if.sv
interface lkm_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [lkm_pkg::BYTE_W-1:0] text_byte;

  modport source (output valid, output op, output text_byte, input ready);
  modport sink (input valid, input op, input text_byte, output ready);
endinterface

interface lkm_res_if;
  logic                           valid;
  logic                           ready;
  logic [lkm_pkg::OUT_LINE_W-1:0] line_no;
  logic                           matched;
  logic                           text_done;

  modport source (output valid, output line_no, output matched, output text_done,
                  input ready);
  modport sink (input valid, input line_no, input matched, input text_done,
                output ready);
endinterface

>>> sv/lkm_cell.sv
module lkm_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lkm_pkg::cell_ctl_t         ctl,
  input  logic [lkm_pkg::BYTE_W-1:0] key_byte,
  input  logic [lkm_pkg::BYTE_W-1:0] text_byte,
  input  logic                       enabled,
  input  logic                       prev_bit,
  output logic                       bit_q,
  output logic                       cand
);
  import lkm_pkg::*;

  logic bit_r;
  logic bit_nxt;

  assign cand = prev_bit & enabled & (key_byte == text_byte);

  always_comb begin
    bit_nxt = bit_r;
    if (ctl.clear) begin
      bit_nxt = 1'b0;
    end else if (ctl.shift) begin
      bit_nxt = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

  assign bit_q = bit_r;

endmodule

>>> sv/line_keyword_match_reporter_top.sv
// channel   dir  fields                              handshake
// in_ch     in   op, text_byte                       valid/ready
// out_ch    out  line_no, matched, text_done         valid/ready
// cfg       in   cfg_index, cfg_wdata                cfg_we, no stall
//
// one request per cycle while out_ch does not stall; a result, when one is due, appears the cycle after its request
// the cell row is registered, one compare per keyword byte
// a single output register: a new request is taken while out_ch is empty or drained
// stall on out_ch blocks in_ch through in_ch.ready
// synchronous reset returns the line counter to one and clears the row
module line_keyword_match_reporter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  lkm_req_if.sink                       in_ch,
  lkm_res_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [lkm_pkg::CFG_W-1:0]     cfg_wdata
);
  import lkm_pkg::*;

  logic [CFG_W-1:0]     key_lo_r;
  logic [CFG_W-1:0]     key_hi_r;
  logic [KEY_LEN_W-1:0] key_len_r;
  logic [KEY_LEN_W-1:0] len_eff;
  logic [2*CFG_W-1:0]   key_all;

  logic [LINE_BITS-1:0] line_cnt_r;
  logic                 line_hit_r;
  logic                 line_nonempty_r;

  logic                 out_valid_r;
  logic [OUT_LINE_W-1:0] out_line_r;
  logic                 out_matched_r;
  logic                 out_done_r;

  logic                 in_acc;
  logic                 is_end;
  logic                 is_nl;
  logic                 len_zero;
  cell_ctl_t            ctl;
  logic [MAX_KEY-1:0]   vec_q;
  logic [MAX_KEY-1:0]   cand;
  logic [MAX_KEY-1:0]   last_sel;
  logic [MAX_KEY:0]     chain;
  logic                 hit_now;
  logic                 emit;
  logic                 emit_match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_LO:  key_lo_r  <= cfg_wdata;
        REG_KEY_HI:  key_hi_r  <= cfg_wdata;
        REG_KEY_LEN: key_len_r <= cfg_wdata[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff  = (key_len_r > KEY_LEN_W'(MAX_KEY)) ? KEY_LEN_W'(MAX_KEY) : key_len_r;
  assign len_zero = (len_eff == '0);
  assign key_all  = {key_hi_r, key_lo_r};

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_end      = (op_t'(in_ch.op) == OP_END);
  assign is_nl       = (in_ch.text_byte == NEWLINE_BYTE);

  assign ctl.clear = in_acc && (is_end || is_nl);
  assign ctl.shift = in_acc && !is_end && !is_nl && !len_zero;

  assign chain[0] = 1'b1;

  for (genvar i = 0; i < MAX_KEY; i++) begin : g_cell
    assign last_sel[i] = (len_eff == KEY_LEN_W'(i + 1));
    assign chain[i+1]  = vec_q[i];

    lkm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key_byte  (key_all[BYTE_W*i +: BYTE_W]),
      .text_byte (in_ch.text_byte),
      .enabled   (KEY_LEN_W'(i) < len_eff),
      .prev_bit  (chain[i]),
      .bit_q     (vec_q[i]),
      .cand      (cand[i])
    );
  end

  assign hit_now = |(cand & last_sel);

  always_comb begin
    emit       = 1'b0;
    emit_match = 1'b0;
    if (is_end) begin
      emit       = 1'b1;
      emit_match = line_nonempty_r && (len_zero || line_hit_r);
    end else if (is_nl) begin
      emit       = len_zero || line_hit_r;
      emit_match = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r      <= LINE_FIRST;
      line_hit_r      <= 1'b0;
      line_nonempty_r <= 1'b0;
    end else if (in_acc) begin
      if (is_end) begin
        line_cnt_r      <= LINE_FIRST;
        line_hit_r      <= 1'b0;
        line_nonempty_r <= 1'b0;
      end else if (is_nl) begin
        if (line_cnt_r != LINE_MAX) begin
          line_cnt_r <= line_cnt_r + LINE_FIRST;
        end
        line_hit_r      <= 1'b0;
        line_nonempty_r <= 1'b0;
      end else begin
        line_nonempty_r <= 1'b1;
        if (ctl.shift && hit_now) begin
          line_hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_acc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_line_r    <= OUT_LINE_W'(line_cnt_r);
      out_matched_r <= emit_match;
      out_done_r    <= is_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.line_no   = out_line_r;
  assign out_ch.matched   = out_matched_r;
  assign out_ch.text_done = out_done_r;

  a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_end) |=> (out_ch.valid && out_ch.text_done))
    else $error("end of text gave no result");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_end) |=> (line_cnt_r == LINE_FIRST && !line_nonempty_r))
    else $error("line state not restarted after end of text");

  a_nl_matched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.text_done) |-> out_ch.matched)
    else $error("line result without match");

  a_hit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    line_hit_r |-> line_nonempty_r)
    else $error("match flagged on empty line");

endmodule

>>> test/line_keyword_match_reporter_top_tb.sv
`timescale 1ns / 100ps

module line_keyword_match_reporter_top_tb;
  import lkm_pkg::*;

  localparam int PHASE_ITEMS   = 75;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 150;
  localparam int QUIET_LIMIT   = 3000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [OUT_LINE_W-1:0] line_no;
    logic                  matched;
    logic                  text_done;
  } line_report_t;

  class line_report_predictor;
    logic [CFG_W-1:0]     key_lo;
    logic [CFG_W-1:0]     key_hi;
    logic [KEY_LEN_W-1:0] key_len;
    logic [MAX_KEY-1:0]   match_vec;
    bit                   line_hit;
    bit                   line_used;
    logic [LINE_BITS-1:0] line_cnt;
    line_report_t         due_reports[$];
    int                   mismatches;
    int                   reports_ok;
    int                   ends_seen;

    function new();
      key_lo     = '0;
      key_hi     = '0;
      key_len    = '0;
      line_cnt   = LINE_FIRST;
      mismatches = 0;
      reports_ok = 0;
      ends_seen  = 0;
      clear_line();
    endfunction

    function void clear_line();
      match_vec = '0;
      line_hit  = 1'b0;
      line_used = 1'b0;
    endfunction

    function int active_len();
      return (key_len > MAX_KEY) ? MAX_KEY : int'(key_len);
    endfunction

    function logic [BYTE_W-1:0] key_byte_at(int i);
      logic [2*CFG_W-1:0] k;
      k = {key_hi, key_lo};
      return k[i*BYTE_W +: BYTE_W];
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_KEY_LO:  key_lo = v;
        REG_KEY_HI:  key_hi = v;
        REG_KEY_LEN: key_len = v[KEY_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_request(op_t op, logic [BYTE_W-1:0] b);
      int                 len;
      logic [MAX_KEY-1:0] eq;
      line_report_t       r;
      len = active_len();
      if (op == OP_END) begin
        r.line_no   = line_cnt[OUT_LINE_W-1:0];
        r.matched   = line_used && (len == 0 || line_hit);
        r.text_done = 1'b1;
        due_reports.push_back(r);
        clear_line();
        line_cnt = LINE_FIRST;
      end else if (b == NEWLINE_BYTE) begin
        if (len == 0 || line_hit) begin
          r.line_no   = line_cnt[OUT_LINE_W-1:0];
          r.matched   = 1'b1;
          r.text_done = 1'b0;
          due_reports.push_back(r);
        end
        if (line_cnt != LINE_MAX) line_cnt++;
        clear_line();
      end else begin
        line_used = 1'b1;
        if (len != 0) begin
          eq = '0;
          for (int i = 0; i < len; i++) begin
            if (key_byte_at(i) == b) eq[i] = 1'b1;
          end
          match_vec = {match_vec[MAX_KEY-2:0], 1'b1} & eq;
          if (match_vec[len-1]) line_hit = 1'b1;
        end
      end
    endfunction

    function void check_report(line_report_t got);
      line_report_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected report: line %0d matched %0b done %0b",
                   got.line_no, got.matched, got.text_done);
        end
        return;
      end
      want = due_reports.pop_front();
      if (want.text_done) ends_seen++;
      if (got.line_no !== want.line_no || got.matched !== want.matched ||
          got.text_done !== want.text_done) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("report mismatch: expected line %0d matched %0b done %0b,",
                   want.line_no, want.matched, want.text_done,
                   " got line %0d matched %0b done %0b",
                   got.line_no, got.matched, got.text_done);
        end
      end else begin
        reports_ok++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  lkm_req_if req_if ();
  lkm_res_if res_if ();

  line_report_predictor pred;
  int items_sent;
  int key_loads;
  int quiet_cycles;
  bit send_busy;
  bit hold_request;

  line_keyword_match_reporter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap(bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (busy || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] filler_byte(int len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && len != 0) return pred.key_byte_at($urandom_range(0, len - 1));
    if (r < 62) return NEWLINE_BYTE;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [2*CFG_W-1:0] make_key(int alpha);
    logic [2*CFG_W-1:0] k;
    for (int i = 0; i < MAX_KEY; i++) begin
      if (alpha == 0) k[i*BYTE_W +: BYTE_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else k[i*BYTE_W +: BYTE_W] = BYTE_W'(8'h61 + $urandom_range(0, alpha - 1));
    end
    return k;
  endfunction

  // each request may idle first; valid stays high across back-to-back requests
  task automatic push_request(op_t op, logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap(send_busy);
    if ($urandom_range(0, 39) == 0) send_busy = !send_busy;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.text_byte <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b);
    push_request(OP_BYTE, b);
  endtask

  task automatic send_end();
    push_request(OP_END, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pred.due_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(logic [2*CFG_W-1:0] k, logic [KEY_LEN_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_LO;
    cfg_wdata <= k[CFG_W-1:0];
    @(posedge clk);
    pred.set_reg(REG_KEY_LO, k[CFG_W-1:0]);
    cfg_index <= REG_KEY_HI;
    cfg_wdata <= k[2*CFG_W-1:CFG_W];
    @(posedge clk);
    pred.set_reg(REG_KEY_HI, k[2*CFG_W-1:CFG_W]);
    cfg_index <= REG_KEY_LEN;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk);
    pred.set_reg(REG_KEY_LEN, CFG_W'(len));
    cfg_we <= 1'b0;
    key_loads++;
  endtask

  // lines built mostly from keyword bytes, with whole or cut keywords dropped in
  task automatic random_text(int budget);
    int stop_at;
    int len;
    int nbytes;
    int insert_at;
    int keep;
    len = pred.active_len();
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 6) begin
        send_end();
      end else begin
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 8);
        insert_at = ($urandom_range(0, 2) != 0) ? $urandom_range(0, nbytes) : -1;
        for (int i = 0; i <= nbytes; i++) begin
          if (i == insert_at && len != 0) begin
            keep = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len;
            for (int j = 0; j < keep; j++) send_byte(pred.key_byte_at(j));
          end
          if (i < nbytes) send_byte(filler_byte(len));
        end
        if ($urandom_range(0, 9) != 0) send_byte(NEWLINE_BYTE);
      end
    end
  endtask

  // result side: random stalls, calm stretches and one long hold-off
  initial begin
    bit drain_busy;
    bit hold_done;
    int stall;
    drain_busy = 1'b0;
    hold_done  = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        res_if.ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_if.ready <= 1'b1;
      end else begin
        stall = pick_gap(drain_busy);
        if ($urandom_range(0, 49) == 0) drain_busy = !drain_busy;
        if (stall != 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        pred.take_request(op_t'(req_if.op), req_if.text_byte);
      end
      if (res_if.valid && res_if.ready) begin
        pred.check_report(line_report_t'({res_if.line_no, res_if.matched,
                                          res_if.text_done}));
      end
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no progress for %0d cycles", QUIET_LIMIT);
        $display("line_keyword_match_reporter_top_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [2*CFG_W-1:0] k;
    pred         = new();
    items_sent   = 0;
    key_loads    = 0;
    quiet_cycles = 0;
    send_busy    = 1'b0;
    rst_n            <= 1'b0;
    hold_request     <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.op        <= OP_BYTE;
    req_if.text_byte <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_KEY_LO;
    cfg_wdata        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty keyword out of reset: every line reports, empty ones too
    send_byte(NEWLINE_BYTE);
    send_byte(8'h00);
    send_byte(NEWLINE_BYTE);
    send_end();
    send_byte(8'hFF);
    send_end();
    settle();

    // short keyword, unused bytes all ones
    load_key({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_6261}, 5'd2);
    send_str("xab\n");
    send_str("ab");
    send_end();
    settle();

    // keyword holding a newline never matches
    load_key({64'h0, 64'h0000_0000_0062_0A61}, 5'd3);
    send_str("a\nb\n");
    send_str("a\nb");
    send_end();
    settle();

    k = make_key(3);
    k[2*CFG_W-1:24] = 104'({$urandom(), $urandom(), $urandom(), $urandom()});
    load_key(k, 5'd3);
    random_text(PHASE_ITEMS);
    send_end();
    settle();

    // full-length keyword, with a pause mid-text until all reports are in
    load_key(make_key(2), 5'd16);
    random_text(PHASE_ITEMS / 2);
    settle();
    random_text(PHASE_ITEMS - PHASE_ITEMS / 2);
    send_end();
    settle();

    // length above the limit acts as a full keyword
    load_key(make_key(2), 5'd31);
    random_text(PHASE_ITEMS);
    send_end();
    settle();

    // empty keyword: every newline reports, result side held off for a while
    load_key({{CFG_W{1'b1}}, {CFG_W{1'b0}}}, 5'd0);
    hold_request <= 1'b1;
    random_text(PHASE_ITEMS);
    send_end();
    settle();

    load_key(make_key(0), 5'd1);
    random_text(PHASE_ITEMS);
    send_end();
    settle();

    load_key(make_key(3), KEY_LEN_W'($urandom_range(4, 15)));
    random_text(PHASE_ITEMS);
    send_end();
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d requests over %0d key settings, lengths 0 to 31",
             items_sent, key_loads);
    $display("checked %0d line reports, %0d of them at end of text, one long result stall",
             pred.reports_ok, pred.ends_seen);
    if (pred.due_reports.size() != 0) begin
      $display("%0d reports never arrived", pred.due_reports.size());
    end
    if (pred.mismatches == 0 && pred.due_reports.size() == 0) begin
      $display("line_keyword_match_reporter_top_tb: clean");
    end else begin
      $display("line_keyword_match_reporter_top_tb: errors");
    end
    $finish;
  end

endmodule
